// ===== rtl/keyed_id_frame_decoder_core_defines.svh =====
// Assertion macros used by the decoder core RTL file.
`ifndef KEYED_ID_FRAME_DECODER_CORE_DEFINES_SVH
`define KEYED_ID_FRAME_DECODER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define KIFD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keyed_id_frame_decoder_core: check failed");
`define KIFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keyed_id_frame_decoder_core: check failed");
`else
`define KIFD_ASSERT_NOW(lbl, ante, cons)
`define KIFD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/kidfd_pkg.sv =====
package kidfd_pkg;

  localparam int MAX_AFFIX_DEFAULT = 8;
  localparam int CFG_INDEX_W       = 3;
  localparam int CFG_DATA_W        = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_PREFIX_CHARS  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PREFIX_LENGTH = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SUFFIX_CHARS  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SUFFIX_LENGTH = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DECIMAL_MODE  = 3'd4;

  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_END  = 1'b1;

  typedef struct packed {
    logic [63:0] acc;
    logic        stopped;
  } conv_t;

  function automatic logic [7:0] affix_byte(input logic [63:0] chars, input logic [2:0] k);
    return chars[8*k +: 8];
  endfunction

  function automatic conv_t convert_char(input conv_t cur, input logic [7:0] c,
                                         input logic dec);
    conv_t nxt;
    logic  is_dig;
    logic  is_alpha;
    nxt      = cur;
    is_dig   = (c >= 8'h30) && (c <= 8'h39);
    is_alpha = ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
    if (dec) begin
      nxt.acc = (cur.acc << 3) + (cur.acc << 1) + {60'd0, (is_dig ? c[3:0] : 4'd0)};
    end else if (!cur.stopped) begin
      if (is_dig) begin
        nxt.acc = {cur.acc[59:0], c[3:0]};
      end else if (is_alpha) begin
        nxt.acc = {cur.acc[59:0], 4'(c[3:0] + 4'd9)};
      end else begin
        nxt.stopped = 1'b1;
      end
    end
    return nxt;
  endfunction

endpackage

// ===== rtl/keyed_id_frame_decoder_core.sv =====
// Decodes a typed card-number frame: characters arrive one item each, then a
// frame-end item returns one result (accepted flag and 64-bit identifier).
// The prefix is checked as it arrives, the last suffix_length characters wait
// in a shift window, and each body character is converted as it leaves the
// window (on arrival if suffix_length is zero). All decode logic sits between
// the frame state registers and the result register, so an item is accepted
// on every cycle, except that a frame-end item is held off while the previous
// result sits untaken in the result register; characters are accepted even
// while a result waits. The result shows in the cycle after its frame-end item.
`include "keyed_id_frame_decoder_core_defines.svh"

module keyed_id_frame_decoder_core #(
  parameter int MAX_AFFIX = kidfd_pkg::MAX_AFFIX_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              op,
  input  logic [7:0]                        character,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              accepted,
  output logic [63:0]                       id_value,
  input  logic                              wr_en,
  input  logic [kidfd_pkg::CFG_INDEX_W-1:0] wr_index,
  input  logic [kidfd_pkg::CFG_DATA_W-1:0]  wr_data
);
  import kidfd_pkg::*;

  localparam int         FILL_W    = $clog2(MAX_AFFIX + 1);
  localparam int         WIN_IDX_W = (MAX_AFFIX > 1) ? $clog2(MAX_AFFIX) : 1;
  localparam logic [3:0] MAX_LEN   = 4'(MAX_AFFIX);

  logic [63:0] prefix_chars;
  logic [3:0]  prefix_length;
  logic [63:0] suffix_chars;
  logic [3:0]  suffix_length;
  logic        decimal_mode;

  logic [7:0]        frame_count;
  logic              prefix_ok;
  logic [7:0]        suffix_window [MAX_AFFIX];
  logic [FILL_W-1:0] window_fill;
  logic [63:0]       accumulator;
  logic              hex_stopped;

  logic [3:0]  p;
  logic [3:0]  s;
  logic        take_char;
  logic        take_end;
  logic        in_body;
  logic        fill_reached;
  logic        conv_en;
  logic [7:0]  conv_byte;
  conv_t       conv_next;
  logic        suffix_match;
  logic        frame_ok;

  assign p = (prefix_length > MAX_LEN) ? MAX_LEN : prefix_length;
  assign s = (suffix_length > MAX_LEN) ? MAX_LEN : suffix_length;

  assign in_stall  = out_valid && out_stall && (op == OP_END);
  assign take_char = in_valid && !in_stall && (op == OP_CHAR);
  assign take_end  = in_valid && !in_stall && (op == OP_END);

  assign in_body      = frame_count >= 8'(p);
  assign fill_reached = 5'(window_fill) >= 5'(s);

  always_comb begin
    conv_en   = 1'b0;
    conv_byte = character;
    if (take_char && in_body) begin
      if (s == 4'd0) begin
        conv_en = 1'b1;
      end else if (fill_reached) begin
        conv_en   = 1'b1;
        conv_byte = suffix_window[WIN_IDX_W'(s - 4'd1)];
      end
    end
    conv_next = convert_char({accumulator, hex_stopped}, conv_byte, decimal_mode);
  end

  always_comb begin
    suffix_match = 1'b1;
    for (int i = 0; i < MAX_AFFIX; i++) begin
      if ((4'(i) < s) &&
          (suffix_window[i] != affix_byte(suffix_chars, 3'(s - 4'(i) - 4'd1)))) begin
        suffix_match = 1'b0;
      end
    end
  end

  assign frame_ok = prefix_ok && (frame_count > (8'(p) + 8'(s))) && fill_reached &&
                    suffix_match;

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_chars  <= '0;
      prefix_length <= '0;
      suffix_chars  <= '0;
      suffix_length <= '0;
      decimal_mode  <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        REG_PREFIX_CHARS:  prefix_chars  <= wr_data;
        REG_PREFIX_LENGTH: prefix_length <= wr_data[3:0];
        REG_SUFFIX_CHARS:  suffix_chars  <= wr_data;
        REG_SUFFIX_LENGTH: suffix_length <= wr_data[3:0];
        REG_DECIMAL_MODE:  decimal_mode  <= wr_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= '0;
      prefix_ok   <= 1'b1;
      window_fill <= '0;
      accumulator <= '0;
      hex_stopped <= 1'b0;
    end else if (take_end) begin
      frame_count <= '0;
      prefix_ok   <= 1'b1;
      window_fill <= '0;
      accumulator <= '0;
      hex_stopped <= 1'b0;
    end else if (take_char) begin
      if (frame_count != 8'hff) begin
        frame_count <= frame_count + 8'd1;
      end
      if (!in_body && (character != affix_byte(prefix_chars, frame_count[2:0]))) begin
        prefix_ok <= 1'b0;
      end
      if (conv_en) begin
        accumulator <= conv_next.acc;
        hex_stopped <= conv_next.stopped;
      end
      if (in_body && (s != 4'd0) && (window_fill != FILL_W'(MAX_AFFIX))) begin
        window_fill <= window_fill + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_char && in_body && (s != 4'd0)) begin
      for (int i = MAX_AFFIX - 1; i > 0; i--) begin
        suffix_window[i] <= suffix_window[i-1];
      end
      suffix_window[0] <= character;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take_end) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_end) begin
      accepted <= frame_ok;
      id_value <= frame_ok ? accumulator : 64'd0;
    end
  end

  `KIFD_ASSERT_NEXT(a_end_gives_result, take_end, out_valid)
  `KIFD_ASSERT_NEXT(a_end_clears_frame, take_end,
                    (frame_count == 8'd0) && prefix_ok && (window_fill == '0))
  `KIFD_ASSERT_NOW(a_rejected_is_zero, out_valid && !accepted, id_value == 64'd0)
  `KIFD_ASSERT_NOW(a_stall_needs_result, in_stall, out_valid && out_stall)
  `KIFD_ASSERT_NOW(a_fill_bound, 1'b1, 5'(window_fill) <= 5'(MAX_AFFIX))

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import kidfd_pkg::*;

  localparam int AFFIX_MAX  = MAX_AFFIX_DEFAULT;
  localparam int COUNT_MAX  = 255;
  localparam int SEGMENTS   = 12;
  localparam int SEG_ITEMS  = 134;
  localparam int SETTLE_CYC = 3;

  typedef struct packed {
    logic        ok;
    logic [63:0] id;
  } frame_res_t;

  typedef enum logic [1:0] {ROW_CHAR, ROW_END, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    logic [CFG_INDEX_W-1:0]   idx;
    logic [63:0]              data;
    frame_res_t               res;
  } stim_row_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   op        = OP_CHAR;
  logic [7:0]             character = 8'h00;
  logic                   out_stall = 1'b0;
  logic                   wr_en     = 1'b0;
  logic [CFG_INDEX_W-1:0] wr_index  = '0;
  logic [CFG_DATA_W-1:0]  wr_data   = '0;
  logic                   in_stall;
  logic                   out_valid;
  logic                   accepted;
  logic [63:0]            id_value;

  keyed_id_frame_decoder_core u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .op       (op),
    .character(character),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .accepted (accepted),
    .id_value (id_value),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always #10 clk = ~clk;

  // shadow registers and frame state
  logic [63:0] cfg_prefix     = '0;
  logic [3:0]  cfg_prefix_len = '0;
  logic [63:0] cfg_suffix     = '0;
  logic [3:0]  cfg_suffix_len = '0;
  logic        cfg_decimal    = 1'b0;

  int          fr_count        = 0;
  logic        fr_prefix_match = 1'b1;
  logic [7:0]  fr_window [AFFIX_MAX];
  int          fr_fill         = 0;
  logic [63:0] fr_acc          = '0;
  logic        fr_hex_done     = 1'b0;

  frame_res_t  frame_results [$];
  stim_row_t   stim_rows [$];
  frame_res_t  want;
  int          send_idle    = 0;
  int          recv_idle    = 0;
  int          mismatches   = 0;
  int          items_sent   = 0;
  int          results_seen = 0;
  int          settings     = 0;

  function automatic int affix_len(input logic [3:0] l);
    return (l > 4'(AFFIX_MAX)) ? AFFIX_MAX : int'(l);
  endfunction

  function automatic void fold_char(input logic [7:0] c);
    if (cfg_decimal) begin
      fr_acc = fr_acc * 64'd10 + ((c >= "0" && c <= "9") ? 64'(c - "0") : 64'd0);
    end else if (!fr_hex_done) begin
      if (c >= "0" && c <= "9") begin
        fr_acc = fr_acc * 64'd16 + 64'(c - "0");
      end else if (c >= "a" && c <= "f") begin
        fr_acc = fr_acc * 64'd16 + 64'(c - "a" + 8'd10);
      end else if (c >= "A" && c <= "F") begin
        fr_acc = fr_acc * 64'd16 + 64'(c - "A" + 8'd10);
      end else begin
        fr_hex_done = 1'b1;
      end
    end
  endfunction

  function automatic logic frame_step(input logic o, input logic [7:0] c,
                                      output frame_res_t r);
    int   p;
    int   s;
    int   i;
    logic ok;
    p = affix_len(cfg_prefix_len);
    s = affix_len(cfg_suffix_len);
    r = '0;
    if (o == OP_CHAR) begin
      if (fr_count < p) begin
        if (c != cfg_prefix[8*fr_count +: 8]) fr_prefix_match = 1'b0;
      end else if (s == 0) begin
        fold_char(c);
      end else begin
        if (fr_fill >= s) fold_char(fr_window[s-1]);
        for (i = AFFIX_MAX - 1; i > 0; i--) fr_window[i] = fr_window[i-1];
        fr_window[0] = c;
        if (fr_fill < AFFIX_MAX) fr_fill++;
      end
      if (fr_count < COUNT_MAX) fr_count++;
      return 1'b0;
    end
    ok = fr_prefix_match && (fr_count > p + s) && (fr_fill >= s);
    for (i = 0; i < s; i++) begin
      if (fr_window[s-1-i] != cfg_suffix[8*i +: 8]) ok = 1'b0;
    end
    r.ok = ok;
    r.id = ok ? fr_acc : 64'd0;
    fr_count        = 0;
    fr_prefix_match = 1'b1;
    fr_fill         = 0;
    fr_acc          = '0;
    fr_hex_done     = 1'b0;
    return 1'b1;
  endfunction

  function automatic void add_row(input row_kind_t k, input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [63:0] d, input logic eo,
                                  input logic [63:0] eid);
    stim_row_t row;
    row.kind   = k;
    row.idx    = idx;
    row.data   = d;
    row.res.ok = eo;
    row.res.id = eid;
    stim_rows.insert(stim_rows.size(), row);
  endfunction

  task automatic push_item(input logic o, input logic [7:0] c, input logic typed,
                           input frame_res_t typed_res);
    frame_res_t r;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    op        <= o;
    character <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (frame_step(o, c, r)) frame_results.insert(frame_results.size(), typed ? typed_res : r);
  endtask

  task automatic let_block_drain;
    in_valid <= 1'b0;
    while (frame_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_PREFIX_CHARS:  cfg_prefix     = data;
      REG_PREFIX_LENGTH: cfg_prefix_len = data[3:0];
      REG_SUFFIX_CHARS:  cfg_suffix     = data;
      REG_SUFFIX_LENGTH: cfg_suffix_len = data[3:0];
      REG_DECIMAL_MODE:  cfg_decimal    = data[0];
      default: ;
    endcase
  endtask

  task automatic configure_segment(input int seg);
    logic [63:0] pc;
    logic [63:0] sc;
    logic [3:0]  pl;
    logic [3:0]  sl;
    logic        dm;
    pc = {$urandom, $urandom};
    sc = {$urandom, $urandom};
    dm = $urandom_range(1);
    pl = ($urandom_range(99) < 80) ? 4'($urandom_range(AFFIX_MAX)) : 4'($urandom_range(15));
    sl = ($urandom_range(99) < 80) ? 4'($urandom_range(AFFIX_MAX)) : 4'($urandom_range(15));
    if (seg == 0) begin
      pc = '1;
      sc = '0;
      pl = 4'd15;
      sl = 4'(AFFIX_MAX);
      dm = 1'b1;
    end else if (seg == 1) begin
      pl = 4'd0;
      sl = 4'd0;
      dm = 1'b0;
    end
    let_block_drain();
    write_reg(REG_PREFIX_CHARS, pc);
    write_reg(REG_PREFIX_LENGTH, {60'({$urandom, $urandom}), pl});
    write_reg(REG_SUFFIX_CHARS, sc);
    write_reg(REG_SUFFIX_LENGTH, {60'({$urandom, $urandom}), sl});
    write_reg(REG_DECIMAL_MODE, {63'({$urandom, $urandom}), dm});
    write_reg(CFG_INDEX_W'($urandom_range(int'(REG_DECIMAL_MODE) + 1, (1 << CFG_INDEX_W) - 1)),
              {$urandom, $urandom});
    settings++;
  endtask

  function automatic logic [7:0] body_char;
    int n;
    if ($urandom_range(99) >= (cfg_decimal ? 85 : 90)) return 8'($urandom_range(255));
    if (cfg_decimal) return 8'("0" + $urandom_range(9));
    n = $urandom_range(21);
    if (n < 10) return 8'("0" + n);
    if (n < 16) return 8'("a" + n - 10);
    return 8'("A" + n - 16);
  endfunction

  task automatic send_frame;
    logic [7:0] frame [$];
    int         p;
    int         s;
    int         n;
    int         kind;
    int         pos;
    int         i;
    p    = affix_len(cfg_prefix_len);
    s    = affix_len(cfg_suffix_len);
    kind = $urandom_range(99);
    if (kind >= 90) begin
      n = $urandom_range(20);
      repeat (n) frame.insert(frame.size(), 8'($urandom_range(255)));
    end else begin
      n = 0;
      if (kind < 80) n = ($urandom_range(99) < 4) ? $urandom_range(250, 265) : $urandom_range(24);
      for (i = 0; i < p; i++) frame.insert(frame.size(), cfg_prefix[8*i +: 8]);
      repeat (n) frame.insert(frame.size(), body_char());
      for (i = 0; i < s; i++) frame.insert(frame.size(), cfg_suffix[8*i +: 8]);
      if (kind >= 80) begin
        pos = $urandom_range(p + s);
        while (frame.size() > pos) void'(frame.pop_back());
      end else if (kind >= 70 && p + s > 0) begin
        pos = $urandom_range(p + s - 1);
        if (pos >= p) pos += n;
        frame[pos] = frame[pos] ^ 8'($urandom_range(1, 255));
      end
    end
    foreach (frame[i]) push_item(OP_CHAR, frame[i], 1'b0, '0);
    push_item(OP_END, 8'($urandom_range(255)), 1'b0, '0);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (frame_results.size() == 0) begin
        $error("result item with no frame end pending: accepted %0d id_value %h",
               accepted, id_value);
        mismatches++;
      end else begin
        want = frame_results.pop_front();
        if (accepted !== want.ok) begin
          $error("accepted: expected %0d, got %0d", want.ok, accepted);
          mismatches++;
        end
        if (id_value !== want.id) begin
          $error("id_value: expected %h, got %h", want.id, id_value);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #10ms;
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    int seg;
    int seg_start;
    add_row(ROW_WRITE, CFG_INDEX_W'((1 << CFG_INDEX_W) - 1), '1, 1'b0, '0);
    add_row(ROW_END,   '0, 64'hA5, 1'b0, 64'd0);
    add_row(ROW_CHAR,  '0, "9", 1'b0, '0);
    add_row(ROW_CHAR,  '0, "F", 1'b0, '0);
    add_row(ROW_CHAR,  '0, "a", 1'b0, '0);
    add_row(ROW_CHAR,  '0, "G", 1'b0, '0);
    add_row(ROW_CHAR,  '0, "1", 1'b0, '0);
    add_row(ROW_END,   '0, 64'h00, 1'b1, 64'h9FA);
    add_row(ROW_CHAR,  '0, 64'h00, 1'b0, '0);
    add_row(ROW_END,   '0, 64'hFF, 1'b1, 64'd0);
    add_row(ROW_WRITE, REG_DECIMAL_MODE, 64'd1, 1'b0, '0);
    add_row(ROW_WRITE, REG_PREFIX_LENGTH, 64'd2, 1'b0, '0);
    add_row(ROW_WRITE, REG_PREFIX_CHARS, 64'h4241, 1'b0, '0);
    add_row(ROW_WRITE, REG_SUFFIX_LENGTH, 64'd1, 1'b0, '0);
    add_row(ROW_WRITE, REG_SUFFIX_CHARS, 64'h23, 1'b0, '0);
    add_row(ROW_CHAR,  '0, "A", 1'b0, '0);
    add_row(ROW_CHAR,  '0, "B", 1'b0, '0);
    add_row(ROW_CHAR,  '0, "1", 1'b0, '0);
    add_row(ROW_CHAR,  '0, 64'hFF, 1'b0, '0);
    add_row(ROW_CHAR,  '0, "7", 1'b0, '0);
    add_row(ROW_CHAR,  '0, "#", 1'b0, '0);
    add_row(ROW_END,   '0, 64'h3C, 1'b1, 64'd107);
    add_row(ROW_CHAR,  '0, "A", 1'b0, '0);
    add_row(ROW_CHAR,  '0, "X", 1'b0, '0);
    add_row(ROW_CHAR,  '0, "5", 1'b0, '0);
    add_row(ROW_CHAR,  '0, "#", 1'b0, '0);
    add_row(ROW_END,   '0, 64'h00, 1'b0, 64'd0);
    add_row(ROW_CHAR,  '0, "A", 1'b0, '0);
    add_row(ROW_CHAR,  '0, "B", 1'b0, '0);
    add_row(ROW_CHAR,  '0, "#", 1'b0, '0);
    add_row(ROW_END,   '0, 64'h00, 1'b0, 64'd0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    send_idle = 38;
    recv_idle = 64;

    foreach (stim_rows[i]) begin
      case (stim_rows[i].kind)
        ROW_CHAR: push_item(OP_CHAR, stim_rows[i].data[7:0], 1'b0, '0);
        ROW_END:  push_item(OP_END, stim_rows[i].data[7:0], 1'b1, stim_rows[i].res);
        default: begin
          let_block_drain();
          write_reg(stim_rows[i].idx, stim_rows[i].data);
        end
      endcase
    end

    for (seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < SEGMENTS / 3) begin
        send_idle = 38;
        recv_idle = 64;
      end else if (seg < 2 * SEGMENTS / 3) begin
        send_idle = 64;
        recv_idle = 38;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      configure_segment(seg);
      seg_start = items_sent;
      while (items_sent - seg_start < SEG_ITEMS) send_frame();
    end

    let_block_drain();
    $display("covered %0d items and %0d frame results over %0d register settings",
             items_sent, results_seen, settings);
    $display("affix lengths 0..15, hex and decimal bodies, broken and overlong frames");
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
